// ===== rtl/cih_pkg.sv =====
// Package: shared types and constants for the chained integer hash table.
package cih_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic CFG_BUCKET_COUNT  = 1'b0;
  localparam logic CFG_DEFAULT_VALUE = 1'b1;

  localparam logic [63:0] MIX_MULT = 64'h0000_0000_27d4_eb2d;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX_A,
    ST_MIX_MUL,
    ST_MIX_HI,
    ST_MIX_FIN,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_ACT,
    ST_POP_WAIT,
    ST_DEL_LINK,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/chained_int_hash_table_core.sv =====
// Top level: chained hash table with memories, hash datapath and control sequencer.
// Per item: hash mix, bit-serial modulo, head read and a walk of the chain, then a write for
//   an insert or a delete, and the result; an unused op goes straight to the result.
// Throughput: one item at a time; the next is taken once the result is transferred.
// Reset and every bucket_count write start a clearing pass that empties heads and refills
//   the free stack.
module chained_int_hash_table_core #(
  parameter int MAX_BUCKETS  = 1024,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_read_value,
  output logic        out_found,
  output logic        out_status,
  output logic [10:0] out_entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cih_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);   // link / count width
  localparam int BCW = $clog2(MAX_BUCKETS + 1);
  localparam int CLR_N = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
  localparam int CW = $clog2(CLR_N + 1);
  localparam int WALK_MAX = POOL_ENTRIES;

  // memories
  logic [LW-1:0] head_mem  [MAX_BUCKETS];
  logic [31:0]   key_mem   [POOL_ENTRIES];
  logic [31:0]   val_mem   [POOL_ENTRIES];
  logic [LW-1:0] link_mem  [POOL_ENTRIES];
  logic [PW-1:0] free_mem  [POOL_ENTRIES];

  state_t state_r, state_nxt;

  logic [BCW-1:0] bucket_count_r;
  logic [31:0]    default_value_r;
  logic [CW-1:0]  clr_cnt_r;
  logic [LW-1:0]  free_top_r;
  logic [LW-1:0]  stored_r;

  logic [1:0]  op_r;
  logic [31:0] key_r, value_r;
  logic [63:0] h_r;
  logic [31:0] mh_r;      // upper half of the mixed value for the second product
  logic [63:0] quo_r;     // dividend shifting out
  logic [BCW:0] rem_r;
  logic [6:0]  div_cnt_r;
  logic [BW-1:0] bucket_r;
  logic [LW-1:0] cur_r, prev_r, head_r;
  logic [CW-1:0] steps_r;
  logic          found_r;

  // registered read data
  logic [LW-1:0] head_rd_r, link_rd_r;
  logic [31:0]   key_rd_r, val_rd_r;
  logic [PW-1:0] free_rd_r;

  logic signed [31:0] res_value_r;
  logic res_found_r, res_status_r;
  logic [10:0] res_count_r;
  logic out_valid_r;

  // memory port controls from the sequencer
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [LW-1:0] head_wd;
  logic          ent_we, val_we, link_we, free_we;
  logic [PW-1:0] ent_wa, link_wa, free_wa;
  logic [LW-1:0] link_wd;
  logic [PW-1:0] free_wd;
  logic [PW-1:0] ent_ra, free_ra;

  // hash helper values
  logic [63:0] h0, h1, h2, hm;
  logic [63:0] mul_lo;
  logic [31:0] mul_hi;
  logic [BCW:0] rem_sh;

  assign h0 = {{32{in_key[31]}}, in_key};
  assign h1 = (h0 ^ 64'd61) ^ (h0 >> 16);
  assign h2 = h_r + (h_r << 3);
  assign hm = h_r ^ (h_r >> 4);
  // 64-bit product split into two 32x32 products, taken in ST_MIX_MUL and ST_MIX_HI
  assign mul_lo = 64'(hm[31:0]) * 64'(MIX_MULT[31:0]);
  assign mul_hi = mh_r * MIX_MULT[31:0];
  assign rem_sh = {rem_r[BCW-1:0], quo_r[63]};

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == ST_IDLE) && !out_valid_r && !in_valid;
  assign out_valid = out_valid_r;
  assign out_read_value  = res_value_r;
  assign out_found       = res_found_r;
  assign out_status      = res_status_r;
  assign out_entry_count = res_count_r;

  function automatic logic [PW-1:0] idx(input logic [LW-1:0] v);
    logic [LW-1:0] t;
    t = v - LW'(1);
    return t[PW-1:0];
  endfunction

  // sequencer
  always_comb begin
    state_nxt = state_r;
    head_we = 1'b0; head_wa = bucket_r; head_wd = '0;
    ent_we = 1'b0; val_we = 1'b0; ent_wa = idx(cur_r);
    link_we = 1'b0; link_wa = idx(cur_r); link_wd = head_r;
    free_we = 1'b0; free_wa = '0; free_wd = '0;
    ent_ra = idx(cur_r);
    free_ra = PW'(free_top_r - LW'(1));
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r < CW'(MAX_BUCKETS)) begin
          head_we = 1'b1; head_wa = clr_cnt_r[BW-1:0];
        end
        if (clr_cnt_r < CW'(POOL_ENTRIES)) begin
          free_we = 1'b1; free_wa = clr_cnt_r[PW-1:0]; free_wd = clr_cnt_r[PW-1:0];
        end
        if (clr_cnt_r == CW'(CLR_N - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_valid && cfg_ready && cfg_index == CFG_BUCKET_COUNT) state_nxt = ST_CLEAR;
        else if (in_valid && !in_stall) begin
          state_nxt = (in_op == OP_NONE) ? ST_OUT : ST_MIX_A;
        end
      end
      ST_MIX_A:   state_nxt = ST_MIX_MUL;
      ST_MIX_MUL: state_nxt = ST_MIX_HI;
      ST_MIX_HI:  state_nxt = ST_MIX_FIN;
      ST_MIX_FIN: state_nxt = ST_DIV;
      ST_DIV:     if (div_cnt_r == 7'd63) state_nxt = ST_HEAD_RD;
      ST_HEAD_RD: state_nxt = ST_HEAD_WAIT;
      ST_HEAD_WAIT: state_nxt = ST_WALK_RD;
      ST_WALK_RD: begin
        if (cur_r == '0 || steps_r == CW'(WALK_MAX)) state_nxt = ST_ACT;
        else state_nxt = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: state_nxt = (key_rd_r == key_r) ? ST_ACT : ST_WALK_RD;
      ST_ACT: begin
        state_nxt = ST_OUT;
        if (op_r == OP_SET) begin
          if (found_r) begin
            val_we = 1'b1;
          end else if (free_top_r != '0) begin
            state_nxt = ST_POP_WAIT;
          end
        end else if (op_r == OP_DEL && found_r) begin
          state_nxt = ST_DEL_LINK;
        end
      end
      ST_POP_WAIT: begin
        ent_we = 1'b1; val_we = 1'b1; ent_wa = free_rd_r;
        link_we = 1'b1; link_wa = free_rd_r; link_wd = head_r;
        head_we = 1'b1; head_wd = LW'(free_rd_r) + LW'(1);
        state_nxt = ST_OUT;
      end
      ST_DEL_LINK: begin
        if (prev_r == '0) begin
          head_we = 1'b1; head_wd = link_rd_r;
        end else begin
          link_we = 1'b1; link_wa = idx(prev_r); link_wd = link_rd_r;
        end
        if (free_top_r < LW'(POOL_ENTRIES)) begin
          free_we = 1'b1; free_wa = PW'(free_top_r); free_wd = idx(cur_r);
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory ports; the head is read at the remainder, so its registered data is ready in the next cycle
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[rem_r[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ent_we) key_mem[ent_wa] <= key_r;
    key_rd_r <= key_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[ent_wa] <= value_r;
    val_rd_r <= val_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_r <= free_mem[free_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      bucket_count_r <= BCW'(MAX_BUCKETS);
      default_value_r <= '0;
      free_top_r <= LW'(POOL_ENTRIES);
      stored_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUCKET_COUNT) begin
          if (cfg_data[10:0] == 11'd0) bucket_count_r <= BCW'(1);
          else if ({21'd0, cfg_data[10:0]} > 32'(MAX_BUCKETS))
            bucket_count_r <= BCW'(MAX_BUCKETS);
          else bucket_count_r <= BCW'(cfg_data[10:0]);
          clr_cnt_r <= '0;
          free_top_r <= LW'(POOL_ENTRIES);
          stored_r <= '0;
        end else begin
          default_value_r <= cfg_data;
        end
      end
      if (state_r == ST_POP_WAIT) begin
        free_top_r <= free_top_r - LW'(1);
        stored_r <= stored_r + LW'(1);
      end
      if (state_r == ST_DEL_LINK) begin
        if (free_top_r < LW'(POOL_ENTRIES)) free_top_r <= free_top_r + LW'(1);
        if (stored_r != '0) stored_r <= stored_r - LW'(1);
      end
      if (state_r == ST_OUT && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r <= in_op; key_r <= in_key; value_r <= in_value;
        h_r <= h1; found_r <= 1'b0;
      end
      ST_MIX_A:   h_r <= h2;
      ST_MIX_MUL: begin
        h_r <= mul_lo;
        mh_r <= hm[63:32];
      end
      ST_MIX_HI:  h_r <= h_r + {mul_hi, 32'd0};
      ST_MIX_FIN: begin
        quo_r <= h_r ^ (h_r >> 15);
        rem_r <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        // restoring bit-serial modulo
        if (rem_sh >= {1'b0, bucket_count_r}) rem_r <= rem_sh - {1'b0, bucket_count_r};
        else rem_r <= rem_sh;
        quo_r <= quo_r << 1;
        div_cnt_r <= div_cnt_r + 7'd1;
      end
      ST_HEAD_RD: bucket_r <= rem_r[BW-1:0];
      ST_HEAD_WAIT: begin
        head_r <= head_rd_r; cur_r <= head_rd_r; prev_r <= '0; steps_r <= '0;
      end
      ST_WALK_WAIT: begin
        if (key_rd_r == key_r) found_r <= 1'b1;
        else begin
          prev_r <= cur_r; cur_r <= link_rd_r; steps_r <= steps_r + CW'(1);
        end
      end
      ST_ACT: begin
        res_found_r <= found_r;
        res_status_r <= (op_r == OP_SET) && !found_r && (free_top_r == '0);
        res_value_r <= (op_r == OP_GET) ? (found_r ? val_rd_r : default_value_r) : '0;
      end
      default: ;
    endcase
    if (state_r == ST_IDLE && in_valid && !in_stall && in_op == OP_NONE) begin
      res_found_r <= 1'b0; res_status_r <= 1'b0; res_value_r <= '0;
    end
    if (state_r == ST_OUT && !out_valid_r) res_count_r <= 11'(stored_r);
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= LW'(POOL_ENTRIES)) else $error("free stack overflow");
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (LW'(free_top_r + stored_r) == LW'(POOL_ENTRIES)))
    else $error("pool accounting broken");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("stray result");

endmodule

// ===== sim/tb_chained_int_hash_table_core.sv =====
// Testbench for the chained integer hash table core: scoreboard, drivers, checks.
module tb_chained_int_hash_table_core;
  import cih_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BUCKETS = 1024;
  localparam int TABLE_POOL    = 1024;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AT       = 300;

  typedef struct {
    logic signed [31:0] read_value;
    logic               found;
    logic               status;
    logic [10:0]        entry_count;
  } reply_t;

  // Scoreboard: own copy of the table, predicts each reply and checks the block
  class table_scoreboard;
    logic [10:0] head_ref[TABLE_BUCKETS];
    logic [31:0] key_ref[TABLE_POOL];
    logic [31:0] value_ref[TABLE_POOL];
    logic [10:0] link_ref[TABLE_POOL];
    logic [9:0]  free_ref[TABLE_POOL];
    int unsigned free_top;
    int unsigned stored;
    int unsigned buckets;
    logic [31:0] dflt;
    reply_t      pending[$];
    int          errors;

    function void clear_table();
      for (int i = 0; i < TABLE_BUCKETS; i++) head_ref[i] = '0;
      for (int i = 0; i < TABLE_POOL; i++) free_ref[i] = i[9:0];
      free_top = TABLE_POOL;
      stored = 0;
    endfunction

    function void power_on();
      for (int i = 0; i < TABLE_POOL; i++) begin
        key_ref[i] = '0;
        value_ref[i] = '0;
        link_ref[i] = '0;
      end
      clear_table();
      buckets = TABLE_BUCKETS;
      dflt = '0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      int unsigned v;
      if (idx == CFG_BUCKET_COUNT) begin
        v = data & 32'h7ff;
        if (v == 0) v = 1;
        if (v > TABLE_BUCKETS) v = TABLE_BUCKETS;
        buckets = v;
        clear_table();
      end else begin
        dflt = data;
      end
    endfunction

    // Wang-style mix on the sign-extended key, 64-bit wraparound
    function logic [63:0] mix(logic [31:0] k);
      logic [63:0] h;
      h = {{32{k[31]}}, k};
      h = (h ^ 64'd61) ^ (h >> 16);
      h = h + (h << 3);
      h = h ^ (h >> 4);
      h = h * 64'h27d4eb2d;
      h = h ^ (h >> 15);
      return h;
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] k, logic [31:0] v);
      int unsigned b, cur, prev, steps, e, nxt;
      reply_t r;
      r.read_value = '0;
      r.found = 1'b0;
      r.status = 1'b0;
      if (op != OP_NONE) begin
        b = 32'(mix(k) % 64'(buckets));
        cur = 32'(head_ref[b]);
        prev = 0;
        steps = 0;
        while (cur != 0 && cur <= TABLE_POOL && steps < TABLE_POOL) begin
          if (key_ref[cur-1] == k) begin
            r.found = 1'b1;
            break;
          end
          prev = cur;
          cur = 32'(link_ref[cur-1]);
          steps++;
        end
        if (op == OP_SET) begin
          if (r.found) value_ref[cur-1] = v;
          else if (free_top == 0) r.status = 1'b1;
          else begin
            free_top--;
            e = 32'(free_ref[free_top]) % TABLE_POOL;
            key_ref[e] = k;
            value_ref[e] = v;
            link_ref[e] = head_ref[b];
            head_ref[b] = 11'(e + 1);
            stored++;
          end
        end else if (op == OP_GET) begin
          r.read_value = r.found ? value_ref[cur-1] : dflt;
        end else if (r.found) begin
          nxt = 32'(link_ref[cur-1]);
          if (prev == 0) head_ref[b] = 11'(nxt);
          else link_ref[prev-1] = 11'(nxt);
          if (free_top < TABLE_POOL) begin
            free_ref[free_top] = 10'(cur - 1);
            free_top++;
          end
          if (stored > 0) stored--;
        end
      end
      r.entry_count = 11'(stored);
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(reply_t got);
      reply_t w;
      if (pending.size() == 0) begin
        report("result with no transfer outstanding");
        return;
      end
      w = pending.pop_front();
      if (got.read_value !== w.read_value)
        report($sformatf("read_value %h, want %h", got.read_value, w.read_value));
      if (got.found !== w.found)
        report($sformatf("found %b, want %b", got.found, w.found));
      if (got.status !== w.status)
        report($sformatf("status %b, want %b", got.status, w.status));
      if (got.entry_count !== w.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, w.entry_count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_read_value;
  logic        out_found;
  logic        out_status;
  logic [10:0] out_entry_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  table_scoreboard sb = new();
  int sent_count = 0;
  int taken_count = 0;
  int idle_cycles = 0;
  logic [31:0] key_pool[24];

  chained_int_hash_table_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_found(out_found),
    .out_status(out_status), .out_entry_count(out_entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // One operation transfer; called at a falling edge, returns at one
  task drive_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = sent_count[6] ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_key = k;
    in_value = v;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(op, k, v);
    sent_count++;
    @(negedge clk);
  endtask

  // Drain outstanding replies, let the block settle, then write one register
  task write_reg(logic idx, logic [31:0] data);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task random_phase(int count);
    int sel;
    logic [1:0] op;
    logic [31:0] k;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) op = OP_SET;
      else if (sel < 70) op = OP_GET;
      else if (sel < 95) op = OP_DEL;
      else op = OP_NONE;
      k = ($urandom_range(0, 99) < 15) ? $urandom : key_pool[$urandom_range(0, 23)];
      drive_op(op, k, $urandom);
    end
  endtask

  // Result side: random stall per transfer, bursts without stall, one long hold-off
  initial begin
    int gap;
    reply_t got;
    forever begin
      gap = taken_count[5] ? 0 : $urandom_range(0, 6);
      if (taken_count == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
        out_stall = 1'b0;
      end
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      got.read_value = out_read_value;
      got.found = out_found;
      got.status = out_status;
      got.entry_count = out_entry_count;
      sb.check_result(got);
      taken_count++;
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sb.power_on();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: extreme keys and values, every op, absent key cases
    drive_op(OP_GET, 32'h0, 32'h0);
    drive_op(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    drive_op(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    drive_op(OP_GET, 32'h8000_0000, 32'hffff_ffff);
    drive_op(OP_GET, 32'h7fff_ffff, 32'h0);
    drive_op(OP_SET, 32'h8000_0000, 32'h0);
    drive_op(OP_GET, 32'h8000_0000, 32'h0);
    drive_op(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
    drive_op(OP_DEL, 32'h5, 32'h0);
    drive_op(OP_DEL, 32'h8000_0000, 32'h0);
    drive_op(OP_GET, 32'h8000_0000, 32'h0);
    drive_op(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
    drive_op(OP_GET, 32'hffff_ffff, 32'h0);

    // bucket count zero means one bucket: exercise unlink at head, middle and tail
    write_reg(CFG_DEFAULT_VALUE, 32'h8000_0000);
    write_reg(CFG_BUCKET_COUNT, 32'h0);
    for (int i = 1; i <= 4; i++) drive_op(OP_SET, i, 32'h100 + i);
    drive_op(OP_DEL, 32'h2, 32'h0);
    drive_op(OP_DEL, 32'h4, 32'h0);
    drive_op(OP_DEL, 32'h1, 32'h0);
    drive_op(OP_GET, 32'h2, 32'h0);
    drive_op(OP_GET, 32'h3, 32'h0);
    drive_op(OP_SET, 32'h2, 32'h55);
    drive_op(OP_GET, 32'h2, 32'h0);

    // oversize bucket count saturates; fill the pool and overflow it
    write_reg(CFG_DEFAULT_VALUE, 32'h7fff_ffff);
    write_reg(CFG_BUCKET_COUNT, 32'h7ff);
    for (int i = 0; i < TABLE_POOL + 3; i++)
      drive_op(OP_SET, 32'h4000_0000 + i * 3, $urandom);
    drive_op(OP_SET, 32'h4000_0000, 32'h1234_5678);
    drive_op(OP_GET, 32'h4000_0000, 32'h0);
    drive_op(OP_GET, 32'h1, 32'h0);
    drive_op(OP_DEL, 32'h4000_0003, 32'h0);
    drive_op(OP_SET, 32'h1, 32'h9);
    drive_op(OP_SET, 32'h2, 32'h9);

    // random phases across bucket counts and defaults
    write_reg(CFG_BUCKET_COUNT, 32'h1);
    write_reg(CFG_DEFAULT_VALUE, $urandom);
    random_phase(120);
    write_reg(CFG_BUCKET_COUNT, $urandom_range(2, 16));
    write_reg(CFG_DEFAULT_VALUE, 32'hffff_ffff);
    random_phase(120);
    write_reg(CFG_BUCKET_COUNT, 32'd1024);
    write_reg(CFG_DEFAULT_VALUE, $urandom);
    random_phase(120);
    write_reg(CFG_BUCKET_COUNT, $urandom_range(17, 1023));
    random_phase(120);
    write_reg(CFG_BUCKET_COUNT, {$urandom} | 32'hffff_f800);
    write_reg(CFG_DEFAULT_VALUE, $urandom);
    random_phase(120);
    write_reg(CFG_BUCKET_COUNT, $urandom_range(2, 7));
    random_phase(120);

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cih_pkg.sv
rtl/chained_int_hash_table_core.sv
sim/tb_chained_int_hash_table_core.sv
